// File: sv/ufil_pkg.sv
`default_nettype none
package ufil_pkg;
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int BLOCK_BYTES_DEF = 256;

    localparam logic [2:0] REQ_RX = 3'd0;
    localparam logic [2:0] REQ_STATUS = 3'd1;
    localparam logic [2:0] REQ_READ = 3'd2;
    localparam logic [2:0] REQ_START_RX = 3'd3;
    localparam logic [2:0] REQ_START_VER = 3'd4;

    localparam logic [2:0] K_TX = 3'd0;
    localparam logic [2:0] K_ERASE = 3'd1;
    localparam logic [2:0] K_WRITE = 3'd2;
    localparam logic [2:0] K_READ = 3'd3;
    localparam logic [2:0] K_FINISH = 3'd4;
    localparam logic [2:0] K_UNPROT = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_PROTO = 2'd1;
    localparam logic [1:0] ST_FLASH = 2'd2;

    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_MAXLEN = 2'd1;
    localparam logic [1:0] CFG_VMAXLEN = 2'd2;
    localparam logic [1:0] CFG_SYNCLIM = 2'd3;

    localparam logic [7:0] C_ACK = 8'h06;
    localparam logic [7:0] C_NAK = 8'h15;
    localparam logic [7:0] C_DONE = 8'h00;
    localparam logic [7:0] C_ERR = 8'hFF;
    localparam logic [7:0] SYNC_A = 8'hEB;
    localparam logic [7:0] SYNC_B = 8'h90;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] data_byte;
        logic       op_ok;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  tx_byte;
        logic [31:0] flash_addr;
        logic [20:0] op_len;
        logic [1:0]  run_status;
        logic        last;
    } out_item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: sv/ufil_fifo.sv
`default_nettype none
module ufil_fifo #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             rd,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;

    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr && !full)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd && !empty)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
        end
    end
endmodule
`default_nettype wire

// File: sv/ufil_engine.sv
`default_nettype none
module ufil_engine #(
    parameter int SECTOR_BYTES = ufil_pkg::SECTOR_BYTES_DEF,
    parameter int BLOCK_BYTES = ufil_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [22:0]         cfg_data,
    input  wire logic                in_valid,
    input  wire ufil_pkg::in_item_t  in_item,
    output logic                     in_take,
    output logic                     out_valid,
    output ufil_pkg::out_item_t      out_item,
    input  wire logic                out_full
);
    localparam logic [3:0] PH_IDLE = 4'd0, PH_HUNT = 4'd1, PH_LEN = 4'd2,
        PH_UNPROT = 4'd3, PH_ERASE = 4'd4, PH_DATA = 4'd5, PH_WRITE = 4'd6,
        PH_ECHO = 4'd7, PH_VERDICT = 4'd8, PH_HOSTCRC = 4'd9, PH_CRCREAD = 4'd10,
        PH_VADDR = 4'd11, PH_VLEN = 4'd12;
    localparam logic [31:0] SMASK = ~(32'(SECTOR_BYTES) - 32'd1);
    localparam logic [32:0] SMASK33 = ~(33'(SECTOR_BYTES) - 33'd1);
    localparam logic [20:0] BLK = 21'(BLOCK_BYTES);
    localparam int BCW = $clog2(BLOCK_BYTES) + 1;

    logic [22:0] base_reg;
    logic [20:0] maxlen_reg, vmaxlen_reg;
    logic [21:0] synclim_reg;
    logic [3:0] phase_reg, phase_next;
    logic verify_reg, verify_next;
    logic [2:0] sm_reg, sm_next;
    logic [21:0] hunt_reg, hunt_next;
    logic [1:0] fbi_reg, fbi_next;
    logic [31:0] ilen_reg, ilen_next, raddr_reg, raddr_next, cur_reg, cur_next;
    logic [20:0] left_reg, left_next;
    logic [BCW-1:0] bc_reg, bc_next;
    logic [32:0] eend_reg, eend_next;
    logic [31:0] hcrc_reg, hcrc_next, crc_reg, crc_next;

    // result sequencer: up to six results from one transaction
    ufil_pkg::out_item_t res_reg [6];
    ufil_pkg::out_item_t res_next [6];
    logic [2:0] rcnt_reg, rcnt_next, ridx_reg;
    logic busy;

    logic [20:0] chunk;
    logic [31:0] wacc;
    logic [31:0] crc_new, crc_fin;

    assign busy = (ridx_reg != rcnt_reg);
    assign in_take = in_valid && !busy;
    assign out_valid = busy;
    always_comb
    begin
        out_item = res_reg[ridx_reg];
        out_item.last = (ridx_reg + 3'd1 == rcnt_reg);
    end

    assign chunk = (left_reg >= BLK) ? BLK : left_reg;
    assign crc_new = ufil_pkg::crc_byte(crc_reg, in_item.data_byte);
    assign crc_fin = ~crc_new;

    always_comb
    begin
        logic [31:0] sh;
        sh = {24'd0, in_item.data_byte} << {fbi_reg, 3'b000};
        wacc = ((fbi_reg == 2'd0) ? 32'd0 : 32'd0) | sh;
    end

    always_comb
    begin
        logic [2:0] n;
        logic [31:0] acc;
        phase_next = phase_reg; verify_next = verify_reg; sm_next = sm_reg;
        hunt_next = hunt_reg; fbi_next = fbi_reg; ilen_next = ilen_reg;
        raddr_next = raddr_reg; cur_next = cur_reg; left_next = left_reg;
        bc_next = bc_reg; eend_next = eend_reg; hcrc_next = hcrc_reg;
        crc_next = crc_reg;
        n = 3'd0;
        acc = '0;
        for (int i = 0; i < 6; i++)
        begin
            res_next[i] = '0;
        end
        case (in_item.req_type)
            ufil_pkg::REQ_RX:
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        hunt_next = hunt_reg + 22'd1;
                        if (in_item.data_byte == (sm_reg[0] ? ufil_pkg::SYNC_B
                                                             : ufil_pkg::SYNC_A))
                            sm_next = sm_reg + 3'd1;
                        else if (in_item.data_byte == ufil_pkg::SYNC_A)
                            sm_next = 3'd1;
                        else
                            sm_next = 3'd0;
                        if (sm_next >= 3'd4)
                        begin
                            sm_next = 3'd0; fbi_next = 2'd0; phase_next = PH_LEN;
                        end
                        else if (hunt_next >= synclim_reg)
                        begin
                            res_next[0].tx_byte = ufil_pkg::C_ERR;
                            res_next[1].out_kind = ufil_pkg::K_FINISH;
                            res_next[1].run_status = ufil_pkg::ST_PROTO;
                            n = 3'd2; phase_next = PH_IDLE;
                        end
                    end
                    PH_LEN, PH_VADDR, PH_VLEN, PH_HOSTCRC:
                    begin
                        fbi_next = fbi_reg + 2'd1;
                        if (phase_reg == PH_VADDR)
                        begin
                            acc = ((fbi_reg == 2'd0) ? 32'd0 : raddr_reg) | wacc;
                            raddr_next = acc;
                        end
                        else if (phase_reg == PH_HOSTCRC)
                        begin
                            acc = ((fbi_reg == 2'd0) ? 32'd0 : hcrc_reg) | wacc;
                            hcrc_next = acc;
                        end
                        else
                        begin
                            acc = ((fbi_reg == 2'd0) ? 32'd0 : ilen_reg) | wacc;
                            ilen_next = acc;
                        end
                        if (fbi_reg == 2'd3)
                        begin
                            case (phase_reg)
                                PH_LEN:
                                begin
                                    if (acc == 32'd0 || acc > {11'd0, maxlen_reg})
                                    begin
                                        res_next[0].tx_byte = ufil_pkg::C_NAK;
                                        res_next[1].out_kind = ufil_pkg::K_FINISH;
                                        res_next[1].run_status = ufil_pkg::ST_PROTO;
                                        n = 3'd2; phase_next = PH_IDLE;
                                    end
                                    else
                                    begin
                                        res_next[0].tx_byte = ufil_pkg::C_ACK;
                                        res_next[1].out_kind = ufil_pkg::K_UNPROT;
                                        n = 3'd2; phase_next = PH_UNPROT;
                                    end
                                end
                                PH_VADDR: phase_next = PH_VLEN;
                                PH_VLEN:
                                begin
                                    if (acc == 32'd0 || acc > {11'd0, vmaxlen_reg})
                                    begin
                                        for (int i = 0; i < 4; i++)
                                        begin
                                            res_next[i].tx_byte = ufil_pkg::C_ERR;
                                        end
                                        res_next[4].out_kind = ufil_pkg::K_FINISH;
                                        res_next[4].run_status = ufil_pkg::ST_PROTO;
                                        n = 3'd5; phase_next = PH_IDLE;
                                    end
                                    else
                                    begin
                                        crc_next = '1; left_next = acc[20:0];
                                        res_next[0].out_kind = ufil_pkg::K_READ;
                                        res_next[0].flash_addr = raddr_reg;
                                        res_next[0].op_len = acc[20:0];
                                        n = 3'd1; phase_next = PH_CRCREAD;
                                    end
                                end
                                default:
                                begin
                                    crc_next = '1; left_next = ilen_reg[20:0];
                                    res_next[0].out_kind = ufil_pkg::K_READ;
                                    res_next[0].flash_addr = raddr_reg;
                                    res_next[0].op_len = ilen_reg[20:0];
                                    n = 3'd1; phase_next = PH_CRCREAD;
                                end
                            endcase
                        end
                    end
                    PH_DATA:
                    begin
                        res_next[0].out_kind = ufil_pkg::K_WRITE;
                        res_next[0].tx_byte = in_item.data_byte;
                        res_next[0].flash_addr = cur_reg;
                        res_next[0].op_len = chunk;
                        n = 3'd1;
                        bc_next = bc_reg + 1'b1;
                        if (21'(bc_next) >= chunk) phase_next = PH_WRITE;
                    end
                    PH_VERDICT:
                    begin
                        if (in_item.data_byte != ufil_pkg::C_ACK)
                        begin
                            res_next[0].out_kind = ufil_pkg::K_FINISH;
                            res_next[0].run_status = ufil_pkg::ST_PROTO;
                            n = 3'd1; phase_next = PH_IDLE;
                        end
                        else
                        begin
                            cur_next = cur_reg + 32'(chunk);
                            left_next = left_reg - chunk;
                            bc_next = '0;
                            if (left_next != 21'd0)
                                phase_next = PH_DATA;
                            else
                            begin
                                res_next[0].tx_byte = ufil_pkg::C_DONE;
                                n = 3'd1; fbi_next = 2'd0; hcrc_next = '0;
                                phase_next = PH_HOSTCRC;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ufil_pkg::REQ_STATUS:
            begin
                case (phase_reg)
                    PH_UNPROT:
                    begin
                        cur_next = raddr_reg & SMASK;
                        eend_next = ({1'b0, raddr_reg} + {1'b0, ilen_reg}
                                     + 33'(SECTOR_BYTES) - 33'd1) & SMASK33;
                        res_next[0].out_kind = ufil_pkg::K_ERASE;
                        res_next[0].flash_addr = raddr_reg & SMASK;
                        n = 3'd1; phase_next = PH_ERASE;
                    end
                    PH_ERASE, PH_WRITE:
                    begin
                        if (!in_item.op_ok)
                        begin
                            res_next[0].tx_byte = ufil_pkg::C_ERR;
                            res_next[1].out_kind = ufil_pkg::K_FINISH;
                            res_next[1].run_status = ufil_pkg::ST_FLASH;
                            n = 3'd2; phase_next = PH_IDLE;
                        end
                        else if (phase_reg == PH_WRITE)
                        begin
                            bc_next = '0;
                            res_next[0].out_kind = ufil_pkg::K_READ;
                            res_next[0].flash_addr = cur_reg;
                            res_next[0].op_len = chunk;
                            n = 3'd1; phase_next = PH_ECHO;
                        end
                        else
                        begin
                            cur_next = cur_reg + 32'(SECTOR_BYTES);
                            if ({1'b0, cur_next} < eend_reg)
                            begin
                                res_next[0].out_kind = ufil_pkg::K_ERASE;
                                res_next[0].flash_addr = cur_next;
                                n = 3'd1;
                            end
                            else
                            begin
                                res_next[0].tx_byte = ufil_pkg::C_ACK;
                                n = 3'd1;
                                cur_next = raddr_reg;
                                left_next = ilen_reg[20:0];
                                bc_next = '0;
                                phase_next = PH_DATA;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ufil_pkg::REQ_READ:
            begin
                if (phase_reg == PH_ECHO)
                begin
                    res_next[0].tx_byte = in_item.data_byte;
                    n = 3'd1;
                    bc_next = bc_reg + 1'b1;
                    if (21'(bc_next) >= chunk) phase_next = PH_VERDICT;
                end
                else if (phase_reg == PH_CRCREAD)
                begin
                    crc_next = crc_new;
                    if (left_reg != 21'd0) left_next = left_reg - 21'd1;
                    if (left_next == 21'd0)
                    begin
                        phase_next = PH_IDLE;
                        if (verify_reg)
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                res_next[i].tx_byte = crc_fin[8*i +: 8];
                            end
                            res_next[4].out_kind = ufil_pkg::K_FINISH;
                            res_next[4].run_status = ufil_pkg::ST_OK;
                            n = 3'd5;
                        end
                        else if (crc_fin == hcrc_reg)
                        begin
                            res_next[0].tx_byte = ufil_pkg::C_ACK;
                            res_next[1].out_kind = ufil_pkg::K_FINISH;
                            res_next[1].run_status = ufil_pkg::ST_OK;
                            n = 3'd2;
                        end
                        else
                        begin
                            res_next[0].tx_byte = ufil_pkg::C_NAK;
                            for (int i = 0; i < 4; i++)
                            begin
                                res_next[i+1].tx_byte = crc_fin[8*i +: 8];
                            end
                            res_next[5].out_kind = ufil_pkg::K_FINISH;
                            res_next[5].run_status = ufil_pkg::ST_PROTO;
                            n = 3'd6;
                        end
                    end
                end
            end
            ufil_pkg::REQ_START_RX, ufil_pkg::REQ_START_VER:
            begin
                sm_next = '0; hunt_next = '0; fbi_next = '0; ilen_next = '0;
                cur_next = '0; left_next = '0; bc_next = '0; eend_next = '0;
                hcrc_next = '0; crc_next = '1;
                if (in_item.req_type == ufil_pkg::REQ_START_RX)
                begin
                    verify_next = 1'b0; raddr_next = {9'd0, base_reg};
                    phase_next = PH_HUNT;
                end
                else
                begin
                    verify_next = 1'b1; raddr_next = '0; phase_next = PH_VADDR;
                end
            end
            default: ;
        endcase
        rcnt_next = n;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < 6; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0; maxlen_reg <= 21'd524288; vmaxlen_reg <= 21'd1048576;
            synclim_reg <= 22'd3000000;
            phase_reg <= PH_IDLE; verify_reg <= 1'b0; sm_reg <= '0; hunt_reg <= '0;
            fbi_reg <= '0; ilen_reg <= '0; raddr_reg <= '0; cur_reg <= '0;
            left_reg <= '0; bc_reg <= '0; eend_reg <= '0; hcrc_reg <= '0;
            crc_reg <= '1; rcnt_reg <= '0; ridx_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ufil_pkg::CFG_BASE: base_reg <= cfg_data;
                    ufil_pkg::CFG_MAXLEN: maxlen_reg <= cfg_data[20:0];
                    ufil_pkg::CFG_VMAXLEN: vmaxlen_reg <= cfg_data[20:0];
                    ufil_pkg::CFG_SYNCLIM: synclim_reg <= cfg_data[21:0];
                    default: ;
                endcase
            end
            if (in_take)
            begin
                phase_reg <= phase_next; verify_reg <= verify_next; sm_reg <= sm_next;
                hunt_reg <= hunt_next; fbi_reg <= fbi_next; ilen_reg <= ilen_next;
                raddr_reg <= raddr_next; cur_reg <= cur_next; left_reg <= left_next;
                bc_reg <= bc_next; eend_reg <= eend_next; hcrc_reg <= hcrc_next;
                crc_reg <= crc_next; rcnt_reg <= rcnt_next; ridx_reg <= '0;
            end
            else if (busy && !out_full)
            begin
                ridx_reg <= ridx_reg + 3'd1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) ridx_reg <= rcnt_reg)
        else $error("result index past count");
    a_max: assert property (@(posedge clk) disable iff (!rst_n) rcnt_reg <= 3'd6)
        else $error("too many results");
    a_noacc: assert property (@(posedge clk) disable iff (!rst_n) busy |-> !in_take)
        else $error("item taken while results pending");
`endif
endmodule
`default_nettype wire

// File: sv/uart_flash_image_loader.sv
// channel | direction | handshake     | payload
// in      | into      | push / full   | in_item (req_type, data_byte, op_ok)
// out     | out of    | pop / empty   | out_item (kind, byte, addr, len, status, last)
// cfg     | into      | cfg_we        | cfg_index, cfg_data
// An item passes the input queue, then the engine's result sequencer, which hands its
// results to the output queue in order while it has room; no new item is taken until then.
// Reset clears all control state and loads the register defaults; no clearing pass.
// Either side may stall: the input and output queues decouple host from engine.
`default_nettype none
module uart_flash_image_loader #(
    parameter int SECTOR_BYTES = ufil_pkg::SECTOR_BYTES_DEF,
    parameter int BLOCK_BYTES = ufil_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [22:0]         cfg_data,
    input  wire logic                push,
    input  wire ufil_pkg::in_item_t  in_item,
    output logic                     full,
    input  wire logic                pop,
    output ufil_pkg::out_item_t      out_item,
    output logic                     empty
);
    localparam int IW = $bits(ufil_pkg::in_item_t);
    localparam int OW = $bits(ufil_pkg::out_item_t);
    logic [IW-1:0] q_data;
    logic q_empty, take, ovalid, ofull;
    ufil_pkg::out_item_t eitem;
    logic [OW-1:0] o_data;

    ufil_fifo #(.WIDTH(IW), .DEPTH(4)) u_inq (
        .clk(clk), .rst_n(rst_n), .wr(push), .wdata(in_item), .full(full),
        .rd(take), .rdata(q_data), .empty(q_empty));

    ufil_engine #(.SECTOR_BYTES(SECTOR_BYTES), .BLOCK_BYTES(BLOCK_BYTES)) u_eng (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(!q_empty), .in_item(q_data), .in_take(take),
        .out_valid(ovalid), .out_item(eitem), .out_full(ofull));

    ufil_fifo #(.WIDTH(OW), .DEPTH(4)) u_outq (
        .clk(clk), .rst_n(rst_n), .wr(ovalid), .wdata(eitem), .full(ofull),
        .rd(pop), .rdata(o_data), .empty(empty));

    assign out_item = o_data;
endmodule
`default_nettype wire
